// ===== rtl/rld_pkg.sv =====
package rld_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned WordW       = 64;
  localparam int unsigned RunCntW     = 6;
  localparam int unsigned KindW       = 2;
  localparam int unsigned NibW        = 4;
  localparam int unsigned RunCapacity = 32;
  localparam logic [RunCntW-1:0] RunLimitMax = RunCntW'(RunCapacity);

  localparam int unsigned OutPackW = 2 * WordW + RunCntW;
  localparam int unsigned OutDataW = ((OutPackW + 7) / 8) * 8;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2,
    PH_DONE   = 2'd3
  } rld_phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_RUN   = 2'd0,
    KIND_END   = 2'd1,
    KIND_TRUNC = 2'd2
  } rld_kind_e;

  typedef struct packed {
    logic signed [WordW-1:0] cluster;
    logic [WordW-1:0]        length;
    logic [RunCntW-1:0]      number;
    rld_kind_e               kind;
    logic                    last;
    logic                    trunc_after;  // truncation beat follows this run
  } rld_entry_t;

endpackage

// ===== rtl/rld_front.sv =====
module rld_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [rld_pkg::ByteW-1:0]     byte_i,
  input  logic                          start_i,
  input  logic                          eob_i,
  input  logic                          cfg_valid_i,
  input  logic [rld_pkg::RunCntW-1:0]   cfg_data_i,
  input  logic                          q_ready_i,
  output logic                          q_push_o,
  output rld_pkg::rld_entry_t           q_entry_o
);

  rld_pkg::rld_phase_e                phase_q, phase_d, phase_c;
  logic [rld_pkg::NibW-1:0]           len_left_q, len_left_d;
  logic [rld_pkg::NibW-1:0]           off_left_q, off_left_d;
  logic [rld_pkg::NibW-1:0]           off_width_q, off_width_d;
  logic [rld_pkg::NibW-1:0]           pos_q, pos_d;
  logic [rld_pkg::WordW-1:0]          len_acc_q, len_acc_d, len_cur;
  logic [rld_pkg::WordW-1:0]          off_acc_q, off_acc_d, off_cur;
  logic [rld_pkg::WordW-1:0]          base_q, base_d, base_c, base_sum;
  logic [rld_pkg::RunCntW-1:0]        runs_q, runs_d, runs_c, runs_inc;
  logic [rld_pkg::RunCntW-1:0]        max_runs_q, lim;
  logic                               accept, complete, trunc;

  function automatic logic [rld_pkg::WordW-1:0] sext(input logic [rld_pkg::WordW-1:0] v,
                                                     input logic [rld_pkg::NibW-1:0] w,
                                                     input logic en);
    logic [rld_pkg::WordW-1:0] r;
    r = v;
    for (int i = 1; i < 8; i++) begin
      if (en && (w == rld_pkg::NibW'(i)) && v[8*i-1]) begin
        r = v | ~((rld_pkg::WordW'(1) << (8 * i)) - rld_pkg::WordW'(1));
      end
    end
    return r;
  endfunction

  assign s_ready_o = q_ready_i;
  assign accept    = s_valid_i & q_ready_i;

  always_comb begin
    if (max_runs_q == '0) begin
      lim = rld_pkg::RunCntW'(1);
    end else if (max_runs_q > rld_pkg::RunLimitMax) begin
      lim = rld_pkg::RunLimitMax;
    end else begin
      lim = max_runs_q;
    end
  end

  always_comb begin
    phase_c  = start_i ? rld_pkg::PH_HEADER : phase_q;
    base_c   = start_i ? '0 : base_q;
    runs_c   = start_i ? '0 : runs_q;
    runs_inc = runs_c + rld_pkg::RunCntW'(1);

    len_cur = len_acc_q;
    off_cur = off_acc_q;
    if (!pos_q[3] && phase_c == rld_pkg::PH_LENGTH) begin
      len_cur[{pos_q[2:0], 3'b000} +: rld_pkg::ByteW] = byte_i;
    end
    if (!pos_q[3] && phase_c == rld_pkg::PH_OFFSET) begin
      off_cur[{pos_q[2:0], 3'b000} +: rld_pkg::ByteW] = byte_i;
    end
    base_sum = base_c + sext(off_cur, off_width_q, len_cur != '0);

    phase_d     = phase_q;
    len_left_d  = len_left_q;
    off_left_d  = off_left_q;
    off_width_d = off_width_q;
    pos_d       = pos_q;
    len_acc_d   = len_acc_q;
    off_acc_d   = off_acc_q;
    base_d      = base_q;
    runs_d      = runs_q;
    complete    = 1'b0;
    trunc       = 1'b0;
    q_push_o    = 1'b0;
    q_entry_o   = '0;

    if (accept) begin
      phase_d = phase_c;
      base_d  = base_c;
      runs_d  = runs_c;
      unique case (phase_c)
        rld_pkg::PH_HEADER: begin
          if (runs_c >= lim) begin
            phase_d = rld_pkg::PH_DONE;
          end else if (byte_i == '0) begin
            q_push_o         = 1'b1;
            q_entry_o.number = runs_c;
            q_entry_o.kind   = rld_pkg::KIND_END;
            q_entry_o.last   = 1'b1;
            phase_d          = rld_pkg::PH_DONE;
          end else begin
            len_left_d  = byte_i[3:0];
            off_left_d  = byte_i[7:4];
            off_width_d = byte_i[7:4];
            pos_d       = '0;
            len_acc_d   = '0;
            off_acc_d   = '0;
            phase_d     = (byte_i[3:0] != '0) ? rld_pkg::PH_LENGTH : rld_pkg::PH_OFFSET;
            trunc       = eob_i;
          end
        end
        rld_pkg::PH_LENGTH: begin
          len_acc_d  = len_cur;
          pos_d      = pos_q + rld_pkg::NibW'(1);
          len_left_d = len_left_q - rld_pkg::NibW'(1);
          if (len_left_q == rld_pkg::NibW'(1)) begin
            if (off_left_q == '0) begin
              complete = 1'b1;
            end else begin
              phase_d = rld_pkg::PH_OFFSET;
              pos_d   = '0;
              trunc   = eob_i;
            end
          end else begin
            trunc = eob_i;
          end
        end
        rld_pkg::PH_OFFSET: begin
          off_acc_d  = off_cur;
          pos_d      = pos_q + rld_pkg::NibW'(1);
          off_left_d = off_left_q - rld_pkg::NibW'(1);
          if (off_left_q == rld_pkg::NibW'(1)) begin
            complete = 1'b1;
          end else begin
            trunc = eob_i;
          end
        end
        default: begin
        end
      endcase

      if (trunc) begin
        q_push_o         = 1'b1;
        q_entry_o.number = runs_c;
        q_entry_o.kind   = rld_pkg::KIND_TRUNC;
        q_entry_o.last   = 1'b1;
        phase_d          = rld_pkg::PH_DONE;
      end

      if (complete) begin
        base_d            = base_sum;
        runs_d            = runs_inc;
        q_push_o          = 1'b1;
        q_entry_o.cluster = base_sum;
        q_entry_o.length  = len_cur;
        q_entry_o.number  = runs_c;
        q_entry_o.kind    = rld_pkg::KIND_RUN;
        if (runs_inc >= lim) begin
          q_entry_o.last = 1'b1;
          phase_d        = rld_pkg::PH_DONE;
        end else begin
          q_entry_o.trunc_after = eob_i;
          phase_d = eob_i ? rld_pkg::PH_DONE : rld_pkg::PH_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= rld_pkg::PH_HEADER;
      len_left_q  <= '0;
      off_left_q  <= '0;
      off_width_q <= '0;
      pos_q       <= '0;
      len_acc_q   <= '0;
      off_acc_q   <= '0;
      base_q      <= '0;
      runs_q      <= '0;
      max_runs_q  <= rld_pkg::RunCntW'(32);
    end else begin
      phase_q     <= phase_d;
      len_left_q  <= len_left_d;
      off_left_q  <= off_left_d;
      off_width_q <= off_width_d;
      pos_q       <= pos_d;
      len_acc_q   <= len_acc_d;
      off_acc_q   <= off_acc_d;
      base_q      <= base_d;
      runs_q      <= runs_d;
      if (cfg_valid_i) begin
        max_runs_q <= cfg_data_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_entry_o.kind != rld_pkg::KIND_RUN) |=> (phase_q == rld_pkg::PH_DONE))
    else $error("marker beat did not stop decoding");

endmodule

// ===== rtl/rld_queue.sv =====
module rld_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rld_pkg::rld_entry_t entry_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                valid_o,
  output rld_pkg::rld_entry_t entry_o
);

  rld_pkg::rld_entry_t          mem_q [rld_pkg::QDepth];
  logic [rld_pkg::QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [rld_pkg::QCntW-1:0]    count_q;

  function automatic logic [rld_pkg::QPtrW-1:0] ptr_inc(input logic [rld_pkg::QPtrW-1:0] p);
    logic [rld_pkg::QPtrW-1:0] r;
    r = (p == rld_pkg::QPtrW'(rld_pkg::QDepth - 1)) ? '0 : p + rld_pkg::QPtrW'(1);
    return r;
  endfunction

  assign ready_o = (count_q != rld_pkg::QCntW'(rld_pkg::QDepth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + rld_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - rld_pkg::QCntW'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> ready_o)
    else $error("queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("queue underflow");

endmodule

// ===== rtl/rld_back.sv =====
module rld_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rld_pkg::rld_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output rld_pkg::rld_entry_t m_entry_o
);

  rld_pkg::rld_entry_t out_q, out_d;
  logic                valid_q, valid_d;
  logic                pend_q, pend_d;
  logic                load;

  assign load      = !valid_q || m_ready_i;
  assign q_pop_o   = load && !(valid_q && pend_q) && q_valid_i;
  assign m_valid_o = valid_q;
  assign m_entry_o = out_q;

  always_comb begin
    out_d   = out_q;
    valid_d = valid_q;
    pend_d  = pend_q;
    if (load) begin
      if (valid_q && pend_q) begin
        out_d         = '0;
        out_d.number  = out_q.number + rld_pkg::RunCntW'(1);
        out_d.kind    = rld_pkg::KIND_TRUNC;
        out_d.last    = 1'b1;
        valid_d       = 1'b1;
        pend_d        = 1'b0;
      end else if (q_valid_i) begin
        out_d             = q_entry_i;
        out_d.trunc_after = 1'b0;
        valid_d           = 1'b1;
        pend_d            = q_entry_i.trunc_after;
      end else begin
        valid_d = 1'b0;
        pend_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (valid_q && out_q.kind == rld_pkg::KIND_RUN && !out_q.last))
    else $error("truncation pending behind a non-run beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_q.kind != rld_pkg::KIND_RUN) |-> out_q.last)
    else $error("marker beat without last");

endmodule

// ===== rtl/runlist_decoder_top.sv =====
// Runlist decoder: takes one runlist byte per clock on the slave stream and emits
// one beat per decoded run, end marker or truncation error on the master stream.
// Input bytes are accepted every cycle while the two-entry result queue has room;
// a result passes through the queue storage and then an output register. A byte
// that completes an entry and is also flagged last yields two beats (run, then
// truncation) unless that run reaches the run limit; the output register sends one
// beat per cycle while the sink is ready. The run limit register is written through
// the cfg channel, which is always ready; write it only while the decoder is idle.
module runlist_decoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [rld_pkg::ByteW-1:0]     s_tdata_i,   // run_byte
  input  logic                          s_tuser_i,   // start_req
  input  logic                          s_tlast_i,   // end_of_bytes
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [rld_pkg::OutDataW-1:0]  m_tdata_o,   // run_cluster, run_length, run_number, pad
  output logic [rld_pkg::KindW-1:0]     m_tuser_o,   // kind
  output logic                          m_tlast_o,   // last
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rld_pkg::RunCntW-1:0]   cfg_data_i   // max_runs
);

  rld_pkg::rld_entry_t push_entry, q_entry, out_entry;
  logic                push, q_ready, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  rld_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_tvalid_i),
    .s_ready_o   (s_tready_o),
    .byte_i      (s_tdata_i),
    .start_i     (s_tuser_i),
    .eob_i       (s_tlast_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .q_ready_i   (q_ready),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  rld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  rld_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (pop),
    .m_valid_o (m_tvalid_o),
    .m_ready_i (m_tready_i),
    .m_entry_o (out_entry)
  );

  assign m_tdata_o = {{(rld_pkg::OutDataW - rld_pkg::OutPackW){1'b0}},
                      out_entry.number, out_entry.length, out_entry.cluster};
  assign m_tuser_o = out_entry.kind;
  assign m_tlast_o = out_entry.last;

endmodule
